// ===== rtl/helix_tube_vertex_generator_core_macros.svh =====
// Assertion macros shared by the block's modules.
// They expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef HELIX_TUBE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define HELIX_TUBE_VERTEX_GENERATOR_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define HTVG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define HTVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/htvg_pkg.sv =====
package htvg_pkg;

    localparam int RADIAL_SEGMENTS_DEF = 16;
    localparam int HELIX_SEGMENTS_DEF  = 200;

    localparam logic [15:0] DefOuter = 16'd1600;
    localparam logic [15:0] DefWire  = 16'd160;
    localparam logic [15:0] DefFree  = 16'd3200;
    localparam logic [7:0]  DefCoils = 8'd8;

    localparam int PAddrW = 4;

    // Ring divider: 26-bit dividends cover ring * coils * 1024 and ring * free length.
    localparam int DivW = 26;

    localparam int SinDepth = 1024;
    localparam logic [9:0] QuarterTurn = 10'd256;
    localparam logic [63:0] PiQ30 = 64'd3373259426;

    // Reciprocals 2^64 / ((2n)(2n+1)), rounded up, for the Taylor series terms.
    // The products stay far below 2^64, so the quotients are exact.
    localparam logic [127:0] TaylorRecip [10] = '{
        ((128'd1 << 64) + 128'd5) / 128'd6,
        ((128'd1 << 64) + 128'd19) / 128'd20,
        ((128'd1 << 64) + 128'd41) / 128'd42,
        ((128'd1 << 64) + 128'd71) / 128'd72,
        ((128'd1 << 64) + 128'd109) / 128'd110,
        ((128'd1 << 64) + 128'd155) / 128'd156,
        ((128'd1 << 64) + 128'd209) / 128'd210,
        ((128'd1 << 64) + 128'd271) / 128'd272,
        ((128'd1 << 64) + 128'd341) / 128'd342,
        ((128'd1 << 64) + 128'd419) / 128'd420
    };

    typedef enum logic [1:0] {
        REG_OUTER = 2'd0,
        REG_WIRE  = 2'd1,
        REG_FREE  = 2'd2,
        REG_COILS = 2'd3
    } t_reg_idx;

    // Spring as used by the datapath, already replaced by defaults if invalid.
    typedef struct packed {
        logic [15:0] hr;
        logic [15:0] wd;
        logic [15:0] fl;
        logic [7:0]  cc;
    } t_spring;

    typedef struct packed {
        logic [9:0]         theta;
        logic [7:0]         ring;
        logic signed [16:0] yc;
    } t_ring;

    typedef logic signed [15:0] t_sin_tab [SinDepth];

    function automatic logic signed [15:0] quarter_sine(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        x = (64'(k) * PiQ30) >> 9;
        x2 = (x * x) >> 30;
        term = x;
        pos = x;
        neg = 64'd0;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            term = 64'((128'(term) * TaylorRecip[n - 1]) >> 64);
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = (pos - neg + 64'd32768) >> 16;
        return 16'(r);
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab t;
        logic signed [15:0] s;
        for (int k = 0; k < SinDepth; k++) begin
            t[k] = 16'sd0;
        end
        for (int k = 0; k <= 256; k++) begin
            s = quarter_sine(k);
            t[k] = s;
            t[512 - k] = s;
            t[(512 + k) % SinDepth] = -s;
            t[(1024 - k) % SinDepth] = -s;
        end
        t[0] = 16'sd0;
        t[512] = 16'sd0;
        return t;
    endfunction

    localparam t_sin_tab SinTab = build_sin_tab();

endpackage

// ===== rtl/htvg_sin_rom.sv =====
module htvg_sin_rom (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [9:0]         i_addr_a,
    input  logic [9:0]         i_addr_b,
    output logic signed [15:0] o_data_a,
    output logic signed [15:0] o_data_b
);
    import htvg_pkg::*;

    logic signed [15:0] r_data_a;
    logic signed [15:0] r_data_b;

    // Synchronous two-port read of the per-turn sine table.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SinTab[i_addr_a];
            r_data_b <= SinTab[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// ===== rtl/htvg_div.sv =====
`include "helix_tube_vertex_generator_core_macros.svh"

module htvg_div #(
    parameter int HELIX_SEGMENTS = htvg_pkg::HELIX_SEGMENTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_ring_index,
    input  htvg_pkg::t_spring i_spring,
    output logic            o_ring_valid,
    input  logic            i_ring_take,
    output htvg_pkg::t_ring o_ring
);
    import htvg_pkg::*;

    localparam int DivShift = DivW + $clog2(HELIX_SEGMENTS);
    localparam int ProdW    = 2 * DivW + 1;
    localparam logic [DivW:0] Recip =
        (DivW + 1)'(((64'd1 << DivShift) + 64'(HELIX_SEGMENTS - 1)) / 64'(HELIX_SEGMENTS));
    localparam logic [7:0] RingMax = (HELIX_SEGMENTS < 256) ? 8'(HELIX_SEGMENTS) : 8'd255;

    logic              r_busy;
    logic              r_done;
    logic [DivW-1:0]   r_na;
    logic [DivW-1:0]   r_nb;
    logic [ProdW-1:0]  r_pa;
    logic [ProdW-1:0]  r_pb;
    logic [7:0]        r_ring;

    logic [7:0]        ring_sat;
    logic [15:0]       prod_cc;
    logic [23:0]       prod_fl;
    logic              accept;

    assign accept   = i_in_valid && o_in_ready;
    assign ring_sat = (i_ring_index > RingMax) ? RingMax : i_ring_index;
    assign prod_cc  = 16'(ring_sat) * 16'(i_spring.cc);
    assign prod_fl  = 24'(ring_sat) * 24'(i_spring.fl);

    // Division by the constant ring count as a multiplication by its rounded-up
    // reciprocal; the dividends are narrow enough for the quotients to be exact.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_na   <= {prod_cc, 10'b0};
            r_nb   <= DivW'(prod_fl);
            r_ring <= ring_sat;
        end else if (r_busy) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
            r_pa   <= ProdW'(r_na) * ProdW'(Recip);
            r_pb   <= ProdW'(r_nb) * ProdW'(Recip);
        end else if (r_done && i_ring_take) begin
            r_done <= 1'b0;
        end
    end

    assign o_in_ready   = !r_busy && !r_done;
    assign o_ring_valid = r_done;
    assign o_ring.theta = r_pa[DivShift +: 10];
    assign o_ring.ring  = r_ring;
    assign o_ring.yc    = $signed({1'b0, r_pb[DivShift +: 16]}) -
                          $signed({2'b00, i_spring.fl[15:1]});

    `HTVG_ASSERT_IMPL(a_busy_done_excl, r_busy, !r_done, "divider busy and done together")
    `HTVG_ASSERT_NEXT(a_start_busy, accept, r_busy, "divider did not start")
    `HTVG_ASSERT_NEXT(a_finish_done, r_busy, r_done && !r_busy, "divider did not finish")
    `HTVG_ASSERT_NEXT(a_done_hold, r_done && !i_ring_take, r_done, "ring result was dropped")

endmodule

// ===== rtl/htvg_vtx.sv =====
`include "helix_tube_vertex_generator_core_macros.svh"

module htvg_vtx #(
    parameter int RADIAL_SEGMENTS = htvg_pkg::RADIAL_SEGMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htvg_pkg::t_spring  i_spring,
    input  logic               i_ring_valid,
    output logic               o_ring_take,
    input  htvg_pkg::t_ring    i_ring,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [11:0]        o_vertex_number,
    output logic               o_last_of_ring
);
    import htvg_pkg::*;

    localparam int SegW = $clog2(RADIAL_SEGMENTS);
    localparam logic [SegW-1:0] LastSeg = SegW'(RADIAL_SEGMENTS - 1);
    localparam logic [SegW:0]   RSeg    = (SegW + 1)'(RADIAL_SEGMENTS);
    localparam logic [9:0]      PhiStep = 10'(SinDepth / RADIAL_SEGMENTS);
    localparam logic [SegW:0]   PhiRem  = (SegW + 1)'(SinDepth % RADIAL_SEGMENTS);

    logic en;
    logic issue;
    logic seg_end;
    logic take;

    // Ring slot and segment sequencer.
    logic                r_slot_vld;
    logic [9:0]          r_theta;
    logic signed [16:0]  r_yc;
    logic [11:0]         r_base;
    logic [SegW-1:0]     r_seg;
    logic [9:0]          r_phi;
    logic [SegW-1:0]     r_phr;
    logic [9:0]          n_phi;
    logic [SegW-1:0]     n_phr;
    logic [SegW:0]       rsum;

    assign en      = !o_out_valid || i_out_ready;
    assign issue   = r_slot_vld && en;
    assign seg_end = (r_seg == LastSeg);
    assign take    = i_ring_valid && (!r_slot_vld || (issue && seg_end));
    assign o_ring_take = take;

    // phi = floor(j * 1024 / R), kept as a quotient and a remainder.
    always_comb begin
        rsum = {1'b0, r_phr} + PhiRem;
        if (rsum >= RSeg) begin
            n_phr = SegW'(rsum - RSeg);
            n_phi = r_phi + PhiStep + 10'd1;
        end else begin
            n_phr = rsum[SegW-1:0];
            n_phi = r_phi + PhiStep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= 1'b0;
            r_seg      <= '0;
            r_phi      <= '0;
            r_phr      <= '0;
        end else if (take) begin
            r_slot_vld <= 1'b1;
            r_seg      <= '0;
            r_phi      <= '0;
            r_phr      <= '0;
            r_theta    <= i_ring.theta;
            r_yc       <= i_ring.yc;
            r_base     <= 12'(16'(i_ring.ring) * 16'(RADIAL_SEGMENTS));
        end else if (issue) begin
            if (seg_end) begin
                r_slot_vld <= 1'b0;
            end
            r_seg <= r_seg + 1'b1;
            r_phi <= n_phi;
            r_phr <= n_phr;
        end
    end

    // Stage 1: sine table reads.
    logic signed [15:0] ring_st;
    logic signed [15:0] ring_ct;
    logic signed [15:0] seg_sp;
    logic signed [15:0] seg_cp;

    htvg_sin_rom u_ring_rom (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (r_theta),
        .i_addr_b (r_theta + QuarterTurn),
        .o_data_a (ring_st),
        .o_data_b (ring_ct)
    );

    htvg_sin_rom u_seg_rom (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (r_phi),
        .i_addr_b (r_phi + QuarterTurn),
        .o_data_a (seg_sp),
        .o_data_b (seg_cp)
    );

    logic               r_s1_vld;
    logic [11:0]        r_s1_vn;
    logic               r_s1_last;
    logic signed [16:0] r_s1_yc;

    // Stage 2: first products.
    logic               r_s2_vld;
    logic [11:0]        r_s2_vn;
    logic               r_s2_last;
    logic signed [16:0] r_s2_yc;
    logic signed [15:0] r_s2_ny;
    logic signed [31:0] r_p_cpct;
    logic signed [31:0] r_p_cpst;
    logic signed [33:0] r_p_hst;
    logic signed [33:0] r_p_hct;
    logic signed [33:0] r_p_wsp;

    // Stage 3: normals and wire offsets.
    logic               r_s3_vld;
    logic [11:0]        r_s3_vn;
    logic               r_s3_last;
    logic signed [15:0] r_q_nx;
    logic signed [15:0] r_q_ny;
    logic signed [15:0] r_q_nz;
    logic signed [33:0] r_q_hst;
    logic signed [33:0] r_q_hct;
    logic signed [33:0] r_q_wnx;
    logic signed [33:0] r_q_wnz;
    logic signed [17:0] r_q_ysum;

    logic signed [16:0] hr_s;
    logic signed [16:0] wd_s;
    logic signed [15:0] nx_c;
    logic signed [15:0] nz_c;
    logic signed [31:0] nx_r;
    logic signed [31:0] nz_r;
    logic signed [33:0] wy_r;

    assign hr_s = $signed({1'b0, i_spring.hr});
    assign wd_s = $signed({1'b0, i_spring.wd});
    assign nx_r = (r_p_cpct + 32'sd8192) >>> 14;
    assign nz_r = (r_p_cpst + 32'sd8192) >>> 14;
    assign nx_c = 16'(nx_r);
    assign nz_c = -16'(nz_r);
    assign wy_r = (r_p_wsp + 34'sd16384) >>> 15;

    // Output stage: final rounding and saturation.
    logic signed [34:0] xsum;
    logic signed [34:0] zsum;
    logic signed [15:0] x_sat;
    logic signed [15:0] z_sat;
    logic signed [16:0] y_sat;

    always_comb begin
        xsum = (35'(r_q_hst) + 35'(r_q_wnx) + 35'sd16384) >>> 15;
        zsum = (35'(r_q_hct) + 35'(r_q_wnz) + 35'sd16384) >>> 15;
        if (xsum > 35'sd32767) begin
            x_sat = 16'sh7fff;
        end else if (xsum < -35'sd32768) begin
            x_sat = -16'sh8000;
        end else begin
            x_sat = 16'(xsum);
        end
        if (zsum > 35'sd32767) begin
            z_sat = 16'sh7fff;
        end else if (zsum < -35'sd32768) begin
            z_sat = -16'sh8000;
        end else begin
            z_sat = 16'(zsum);
        end
        if (r_q_ysum > 18'sd65535) begin
            y_sat = 17'sh0ffff;
        end else if (r_q_ysum < -18'sd65536) begin
            y_sat = -17'sh10000;
        end else begin
            y_sat = 17'(r_q_ysum);
        end
    end

    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= issue;
            r_s1_vn   <= r_base + 12'(r_seg);
            r_s1_last <= seg_end;
            r_s1_yc   <= r_yc;

            r_s2_vld  <= r_s1_vld;
            r_s2_vn   <= r_s1_vn;
            r_s2_last <= r_s1_last;
            r_s2_yc   <= r_s1_yc;
            r_s2_ny   <= seg_sp;
            r_p_cpct  <= 32'(seg_cp) * 32'(ring_ct);
            r_p_cpst  <= 32'(seg_cp) * 32'(ring_st);
            r_p_hst   <= 34'(hr_s) * 34'(ring_st);
            r_p_hct   <= 34'(hr_s) * 34'(ring_ct);
            r_p_wsp   <= 34'(wd_s) * 34'(seg_sp);

            r_s3_vld  <= r_s2_vld;
            r_s3_vn   <= r_s2_vn;
            r_s3_last <= r_s2_last;
            r_q_nx    <= nx_c;
            r_q_ny    <= r_s2_ny;
            r_q_nz    <= nz_c;
            r_q_hst   <= r_p_hst;
            r_q_hct   <= r_p_hct;
            r_q_wnx   <= 34'(wd_s) * 34'(nx_c);
            r_q_wnz   <= 34'(wd_s) * 34'(nz_c);
            r_q_ysum  <= 18'(r_s2_yc) + 18'(wy_r);

            r_out_vld       <= r_s3_vld;
            o_pos_x         <= x_sat;
            o_pos_y         <= y_sat;
            o_pos_z         <= z_sat;
            o_norm_x        <= r_q_nx;
            o_norm_y        <= r_q_ny;
            o_norm_z        <= r_q_nz;
            o_vertex_number <= r_s3_vn;
            o_last_of_ring  <= r_s3_last;
        end
    end

    assign o_out_valid = r_out_vld;

    `HTVG_ASSERT_IMPL(a_seg_bound, r_slot_vld, r_seg <= LastSeg, "segment counter out of range")
    `HTVG_ASSERT_NEXT(a_load_seg0, take, r_slot_vld && r_seg == '0, "ring load did not restart segments")
    `HTVG_ASSERT_NEXT(a_stall_hold, r_out_vld && !i_out_ready, r_out_vld, "stalled vertex was dropped")

endmodule

// ===== rtl/helix_tube_vertex_generator_core.sv =====
// The first vertex item of a ring is offered once the ring item has passed the ring divider
// (busy, then done), the load of the segment sequencer and the vertex pipeline stages.
// Throughput: one vertex item per cycle while the receiver is ready; the segment sequencer takes
// a new ring item as it issues the last segment, and the divider prepares the next one meanwhile.
// Reset (i_rst_n, synchronous, active low) restores the default spring registers
// and empties the divider and the vertex pipeline; the sine table is a constant ROM.
module helix_tube_vertex_generator_core #(
    parameter int RADIAL_SEGMENTS = htvg_pkg::RADIAL_SEGMENTS_DEF,
    parameter int HELIX_SEGMENTS  = htvg_pkg::HELIX_SEGMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [htvg_pkg::PAddrW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Ring items in.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_ring_index,
    // Vertex items out.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_pos_x,
    output logic signed [16:0]          o_pos_y,
    output logic signed [15:0]          o_pos_z,
    output logic signed [15:0]          o_norm_x,
    output logic signed [15:0]          o_norm_y,
    output logic signed [15:0]          o_norm_z,
    output logic [11:0]                 o_vertex_number,
    output logic                        o_last_of_ring
);
    import htvg_pkg::*;

    // Spring registers. Register i sits at byte address 4*i; the low two
    // address bits are not decoded.
    logic [15:0] r_outer;
    logic [15:0] r_wire;
    logic [15:0] r_free;
    logic [7:0]  r_coils;
    logic        cfg_wr;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= DefOuter;
            r_wire  <= DefWire;
            r_free  <= DefFree;
            r_coils <= DefCoils;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_OUTER: r_outer <= pwdata[15:0];
                REG_WIRE:  r_wire  <= pwdata[15:0];
                REG_FREE:  r_free  <= pwdata[15:0];
                REG_COILS: r_coils <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OUTER: prdata = 32'(r_outer);
            REG_WIRE:  prdata = 32'(r_wire);
            REG_FREE:  prdata = 32'(r_free);
            REG_COILS: prdata = 32'(r_coils);
            default:   prdata = 32'd0;
        endcase
    end

    // A spring with any zero value, or a wire at least as thick as the coil,
    // is replaced as a whole by the default spring. The user must make configuration changes
    // only while the block is idle, which the block does not enforce; the datapath reads this directly.
    t_spring spring;
    logic    spring_bad;

    assign spring_bad = (r_outer == 16'd0) || (r_wire == 16'd0) || (r_free == 16'd0) ||
                        (r_coils == 8'd0) || (r_outer <= r_wire);

    always_comb begin
        if (spring_bad) begin
            spring.hr = DefOuter - DefWire;
            spring.wd = DefWire;
            spring.fl = DefFree;
            spring.cc = DefCoils;
        end else begin
            spring.hr = r_outer - r_wire;
            spring.wd = r_wire;
            spring.fl = r_free;
            spring.cc = r_coils;
        end
    end

    // The divider turns a ring index into its helix angle and axial center;
    // the vertex pipeline then sweeps the tube cross section around it.
    logic  ring_valid;
    logic  ring_take;
    t_ring ring;

    htvg_div #(
        .HELIX_SEGMENTS (HELIX_SEGMENTS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ring_index (i_ring_index),
        .i_spring     (spring),
        .o_ring_valid (ring_valid),
        .i_ring_take  (ring_take),
        .o_ring       (ring)
    );

    htvg_vtx #(
        .RADIAL_SEGMENTS (RADIAL_SEGMENTS)
    ) u_vtx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_spring        (spring),
        .i_ring_valid    (ring_valid),
        .o_ring_take     (ring_take),
        .i_ring          (ring),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_norm_x        (o_norm_x),
        .o_norm_y        (o_norm_y),
        .o_norm_z        (o_norm_z),
        .o_vertex_number (o_vertex_number),
        .o_last_of_ring  (o_last_of_ring)
    );

endmodule

// ===== verif/helix_tube_vertex_generator_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the helix tube vertex generator. Each ring item
// driven into the block is run through a local predictor, which appends the
// sixteen vertex items it should produce to a queue. Every vertex item
// that leaves the block is compared field by field against the oldest entry.
module helix_tube_vertex_generator_core_tb;

    import htvg_pkg::*;

    localparam int NUM_SEG   = 16;
    localparam int NUM_RINGS = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    // One expected vertex item.
    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [11:0]        vnum;
        logic               last;
    } vertex_t;

    // A directed row. Where known_first is set, the first vertex of the ring
    // has a number and a position that can be worked out by hand.
    typedef struct {
        logic [7:0]         ring;
        bit                 known_first;
        logic [11:0]        vnum;
        logic signed [15:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [15:0] pos_z;
    } ring_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PAddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_ring_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [15:0] o_pos_x;
    logic signed [16:0] o_pos_y;
    logic signed [15:0] o_pos_z;
    logic signed [15:0] o_norm_x;
    logic signed [15:0] o_norm_y;
    logic signed [15:0] o_norm_z;
    logic [11:0] o_vertex_number;
    logic        o_last_of_ring;

    helix_tube_vertex_generator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_ring_index    (i_ring_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_norm_x        (o_norm_x),
        .o_norm_y        (o_norm_y),
        .o_norm_z        (o_norm_z),
        .o_vertex_number (o_vertex_number),
        .o_last_of_ring  (o_last_of_ring)
    );

    // Predictor state: the spring registers as written and the sine table.
    logic [15:0] spring_outer;
    logic [15:0] spring_wire;
    logic [15:0] spring_free;
    logic [7:0]  spring_coils;
    int          sine_rom [1024];

    vertex_t     vertex_fifo[$];
    int          fail_count;
    int          cycle_count;
    bit          quiet_sides;
    int          hold_req;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Quarter-wave sine in Q1.14, from a truncated Taylor series in Q30.
    function automatic int taylor_sine(int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned plus_sum;
        longint unsigned minus_sum;
        ang = (longint'(k) * 64'd3373259426) / 64'd512;
        ang_sq = (ang * ang) >> 30;
        term = ang;
        plus_sum = ang;
        minus_sum = 0;
        for (int n = 1; n <= 10; n++) begin
            term = (term * ang_sq) >> 30;
            term = term / (longint'(2 * n) * longint'(2 * n + 1));
            if (n % 2 == 1) begin
                minus_sum += term;
            end else begin
                plus_sum += term;
            end
        end
        return int'((plus_sum - minus_sum + 64'd32768) >> 16);
    endfunction

    // Round half toward plus infinity, then drop s fraction bits.
    function automatic longint round_down_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Work out the sixteen vertex items of one ring and queue them.
    task automatic predict_ring_vertices(input logic [7:0] ring_in);
        longint outer;
        longint wire_dia;
        longint free;
        longint coils;
        longint ring;
        longint sin_t;
        longint cos_t;
        longint y_center;
        longint sin_p;
        longint cos_p;
        longint nx;
        longint nz;
        int     theta;
        int     phi;
        vertex_t v;
        outer = spring_outer;
        wire_dia = spring_wire;
        free = spring_free;
        coils = spring_coils;
        // An invalid spring falls back to the default one.
        if (outer == 0 || wire_dia == 0 || free == 0 || coils == 0 || outer <= wire_dia) begin
            outer = 1600;
            wire_dia = 160;
            free = 3200;
            coils = 8;
        end
        ring = (ring_in > NUM_RINGS) ? NUM_RINGS : ring_in;
        theta = int'((ring * coils * 1024 / NUM_RINGS) % 1024);
        sin_t = sine_rom[theta];
        cos_t = sine_rom[(theta + 256) % 1024];
        y_center = ring * free / NUM_RINGS - (free >> 1);
        for (int j = 0; j < NUM_SEG; j++) begin
            phi = j * 1024 / NUM_SEG;
            sin_p = sine_rom[phi];
            cos_p = sine_rom[(phi + 256) % 1024];
            nx = round_down_shift(cos_p * cos_t, 14);
            nz = -round_down_shift(cos_p * sin_t, 14);
            v.pos_x = 16'(clamp(round_down_shift((outer - wire_dia) * sin_t + wire_dia * nx, 15),
                                -32768, 32767));
            v.pos_z = 16'(clamp(round_down_shift((outer - wire_dia) * cos_t + wire_dia * nz, 15),
                                -32768, 32767));
            v.pos_y = 17'(clamp(y_center + round_down_shift(wire_dia * sin_p, 15),
                                -65536, 65535));
            v.norm_x = 16'(nx);
            v.norm_y = 16'(sin_p);
            v.norm_z = 16'(nz);
            v.vnum = 12'(ring * NUM_SEG + j);
            v.last = (j == NUM_SEG - 1);
            vertex_fifo = {vertex_fifo, v};
        end
    endtask

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < 30) begin
            $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        end
        fail_count++;
    endtask

    // APB write: setup cycle, then the access cycle that commits the register.
    // The select stays up between the writes of one spring and is dropped by
    // set_spring, so no signal is assigned twice at one edge.
    task automatic write_spring_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PAddrW'(4 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        case (idx)
            REG_OUTER: spring_outer = value[15:0];
            REG_WIRE: spring_wire = value[15:0];
            REG_FREE: spring_free = value[15:0];
            REG_COILS: spring_coils = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_spring(input int outer, input int wire_dia, input int free,
                              input int coils);
        write_spring_reg(REG_OUTER, outer);
        write_spring_reg(REG_WIRE, wire_dia);
        write_spring_reg(REG_FREE, free);
        write_spring_reg(REG_COILS, coils);
        psel <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one ring item after a random gap and predict it once accepted.
    // Valid is only lowered when a gap follows, so it is never lowered and
    // raised again within one time step.
    task automatic send_ring(input logic [7:0] ring);
        int gap;
        gap = quiet_sides ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ring_index <= ring;
        do @(posedge i_clk); while (!o_in_ready);
        predict_ring_vertices(ring);
    endtask

    // Waits until every expected vertex item has come out, then lets the
    // pipeline settle before the configuration is touched.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (vertex_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_ring();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(NUM_RINGS + 1, 255));
        end
        return 8'($urandom_range(0, NUM_RINGS));
    endfunction

    // Receiver: a random stall after each vertex item outside the quiet phases, and
    // once a long hold-off so that the block backs up into its input.
    int stall_left;
    int stall_draw;
    int hold_left;
    int hold_seen;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            if (quiet_sides) begin
                stall_left <= 0;
                i_out_ready <= 1'b1;
            end else begin
                stall_draw = $urandom_range(0, 5);
                stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
                i_out_ready <= (stall_draw == 0);
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Output checker, sampling the values that stood before the edge.
    always @(posedge i_clk) begin
        vertex_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vertex_fifo.size() == 0) begin
                report_mismatch("unexpected vertex, number", o_vertex_number, -1);
            end else begin
                want = vertex_fifo.pop_front();
                if (o_pos_x !== want.pos_x) report_mismatch("pos_x", o_pos_x, want.pos_x);
                if (o_pos_y !== want.pos_y) report_mismatch("pos_y", o_pos_y, want.pos_y);
                if (o_pos_z !== want.pos_z) report_mismatch("pos_z", o_pos_z, want.pos_z);
                if (o_norm_x !== want.norm_x) report_mismatch("norm_x", o_norm_x, want.norm_x);
                if (o_norm_y !== want.norm_y) report_mismatch("norm_y", o_norm_y, want.norm_y);
                if (o_norm_z !== want.norm_z) report_mismatch("norm_z", o_norm_z, want.norm_z);
                if (o_vertex_number !== want.vnum) begin
                    report_mismatch("vertex_number", o_vertex_number, want.vnum);
                end
                if (o_last_of_ring !== want.last) begin
                    report_mismatch("last_of_ring", o_last_of_ring, want.last);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Directed rings under the reset spring. Ring 0 and ring 255 (which
    // saturates to the last ring, a whole number of turns later) both sit at
    // theta zero, so their first vertex lies at x = wire/2 and
    // z = (outer - wire)/2 with y at the bottom or the top of the spring.
    ring_row_t ring_table [] = '{
        '{8'd0,   1'b1, 12'd0,    16'sd80, -17'sd1600, 16'sd720},
        '{8'd1,   1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd12,  1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd25,  1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd50,  1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd100, 1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd170, 1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd199, 1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd200, 1'b1, 12'd3200, 16'sd80, 17'sd1600,  16'sd720},
        '{8'd201, 1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0},
        '{8'd255, 1'b1, 12'd3200, 16'sd80, 17'sd1600,  16'sd720},
        '{8'd170, 1'b0, 12'd0,    16'sd0,  17'sd0,     16'sd0}
    };

    // Spring settings for the random phases: ordinary, the extremes, the
    // smallest valid spring, and the invalid ones that fall back to defaults.
    int springs [8][4] = '{
        '{2000, 400, 6400, 3},
        '{65535, 1, 65535, 255},
        '{0, 160, 3200, 8},
        '{500, 500, 1000, 5},
        '{2, 1, 1, 1},
        '{65535, 65534, 65535, 255},
        '{1600, 1700, 3200, 8},
        '{3000, 200, 0, 0}
    };

    initial begin
        int first;
        int outer;
        fail_count = 0;
        cycle_count = 0;
        quiet_sides = 1'b0;
        hold_req = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_ring_index = '0;
        spring_outer = 16'd1600;
        spring_wire = 16'd160;
        spring_free = 16'd3200;
        spring_coils = 8'd8;
        for (int k = 0; k <= 256; k++) begin
            sine_rom[k] = taylor_sine(k);
            sine_rom[512 - k] = sine_rom[k];
            sine_rom[(512 + k) % 1024] = -sine_rom[k];
            sine_rom[(1024 - k) % 1024] = -sine_rom[k];
        end
        sine_rom[0] = 0;
        sine_rom[512] = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (ring_table[r]) begin
            send_ring(ring_table[r].ring);
            if (ring_table[r].known_first) begin
                first = vertex_fifo.size() - NUM_SEG;
                if (vertex_fifo[first].vnum !== ring_table[r].vnum) begin
                    report_mismatch("hand vertex_number", vertex_fifo[first].vnum,
                                    ring_table[r].vnum);
                end
                if (vertex_fifo[first].pos_x !== ring_table[r].pos_x) begin
                    report_mismatch("hand pos_x", vertex_fifo[first].pos_x, ring_table[r].pos_x);
                end
                if (vertex_fifo[first].pos_y !== ring_table[r].pos_y) begin
                    report_mismatch("hand pos_y", vertex_fifo[first].pos_y, ring_table[r].pos_y);
                end
                if (vertex_fifo[first].pos_z !== ring_table[r].pos_z) begin
                    report_mismatch("hand pos_z", vertex_fifo[first].pos_z, ring_table[r].pos_z);
                end
            end
        end

        for (int p = 0; p < 9; p++) begin
            drain_block();
            if (p < 8) begin
                set_spring(springs[p][0], springs[p][1], springs[p][2], springs[p][3]);
            end else begin
                // One fully random valid spring at the end.
                outer = $urandom_range(2, 65535);
                set_spring(outer, $urandom_range(1, outer - 1), $urandom_range(1, 65535),
                           $urandom_range(1, 255));
            end
            // Every third phase runs with no idling on either side.
            quiet_sides = (p % 3 == 1);
            // Back the block up once while the sender keeps offering rings.
            if (p == 2) hold_req = hold_req + 1;
            for (int n = 0; n < 55; n++) begin
                send_ring(random_ring());
            end
        end

        drain_block();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
